[hw/rtl/jfps_pkg.sv]
// Shared constants and types of the five-point Jacobi stencil unit.
`default_nettype none

package jfps_pkg;

    // Grid geometry and data format.
    localparam int LINE_LENGTH = 1024;
    localparam int DATA_BITS   = 32;
    localparam int COL_BITS    = $clog2(LINE_LENGTH);
    localparam int ROW_BITS    = 16;

    // Interior size limits and reset values.
    localparam int WIDTH_MAX    = LINE_LENGTH - 2;
    localparam int HEIGHT_MAX   = 65534;
    localparam int WIDTH_RESET  = 1022;
    localparam int HEIGHT_RESET = 1022;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 1'd1;

    // Scaling by 0.2 as 13107 / 65536 with round to nearest.
    localparam int SUM_BITS   = DATA_BITS + 3;
    localparam int COEF_BITS  = 14;
    localparam int COEF_MUL   = 13107;
    localparam int COEF_SHIFT = 16;
    localparam int PROD_BITS  = SUM_BITS + COEF_BITS + 1;
    localparam logic signed [COEF_BITS:0] COEF_Q = (COEF_BITS + 1)'(COEF_MUL);
    localparam logic signed [PROD_BITS-1:0] ROUND_BIAS = PROD_BITS'(1) << (COEF_SHIFT - 1);

    // Control that travels with a sum into the scaling stage.
    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/jfps_scale.sv]
// Scaling stage: multiplies the five-point sum by 0.2, rounds and holds the output word.
`default_nettype none

module jfps_scale (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire jfps_pkg::stage_ctl_t                ctl,
    input  wire logic signed [jfps_pkg::SUM_BITS-1:0] sum,
    output logic                                     ready,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [jfps_pkg::DATA_BITS-1:0]           m_axis_tdata,  // new_value
    output logic                                     m_axis_tlast   // last_of_sweep
);

    logic signed [jfps_pkg::PROD_BITS-1:0] prod;
    logic signed [jfps_pkg::PROD_BITS-1:0] scaled;
    logic                                  valid_reg;
    logic [jfps_pkg::DATA_BITS-1:0]        data_reg;
    logic                                  last_reg;

    assign prod   = jfps_pkg::PROD_BITS'(sum) * jfps_pkg::COEF_Q + jfps_pkg::ROUND_BIAS;
    assign scaled = prod >>> jfps_pkg::COEF_SHIFT;

    // The output register frees itself whenever the word is taken.
    assign ready = !valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready && ctl.valid)
        begin
            data_reg <= scaled[jfps_pkg::DATA_BITS-1:0];
            last_reg <= ctl.last;
        end
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tlast  = last_reg;

endmodule

`default_nettype wire

[hw/rtl/jacobi_five_point_stencil_unit.sv]
// Top level of the streaming five-point Jacobi stencil unit.
// The unit takes the padded grid in row-major order, one signed Q16.16 word per cycle,
// and returns 0.2 times the sum of each interior cell and its four neighbours, in
// row-major order, with tlast on the final interior cell. One word is accepted every
// cycle unless a result waits on a stalled output; each result passes three stages,
// the line memory read, the five-term add and the scaling multiply.
// The previous two padded rows live in one line memory of LINE_LENGTH entries, read
// in the accept cycle and written back once the word moves on; it needs no clearing
// after reset. Writing either size register restarts the sweep at the top-left corner.
`default_nettype none

module jacobi_five_point_stencil_unit (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     cfg_we,
    input  wire logic [jfps_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  wire logic [jfps_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    input  wire logic                                     s_axis_tvalid,
    output logic                                          s_axis_tready,
    input  wire logic [jfps_pkg::DATA_BITS-1:0]           s_axis_tdata,  // cell_value
    output logic                                          m_axis_tvalid,
    input  wire logic                                     m_axis_tready,
    output logic [jfps_pkg::DATA_BITS-1:0]                m_axis_tdata,  // new_value
    output logic                                          m_axis_tlast   // last_of_sweep
);

    localparam int DB = jfps_pkg::DATA_BITS;
    localparam int CB = jfps_pkg::COL_BITS;
    localparam int RB = jfps_pkg::ROW_BITS;

    // Sweep position and geometry.
    logic [CB-1:0] col_reg, col_next;
    logic [RB-1:0] row_reg, row_next;
    logic [CB-1:0] last_col_reg, last_col_next;
    logic [RB-1:0] last_row_reg, last_row_next;
    logic [CB-1:0] cfg_w;
    logic [RB-1:0] cfg_h;
    logic          accept;
    logic          in_emit;
    logic          in_last;

    // Line memory: low half holds the previous row, high half the row before that.
    logic [2*DB-1:0] line_mem [jfps_pkg::LINE_LENGTH];
    logic [2*DB-1:0] mem_rd_reg;

    // Stage one: word waiting for its line memory data.
    logic          s1_valid_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;
    logic [CB-1:0] s1_col_reg;
    logic [DB-1:0] s1_x_reg;
    logic          s1_move;
    logic signed [DB-1:0] near_val;
    logic signed [DB-1:0] far_val;

    // Window of the three rows one and two columns back.
    logic signed [DB-1:0] up_reg;
    logic signed [DB-1:0] mid_reg;
    logic signed [DB-1:0] left_reg;
    logic signed [DB-1:0] down_reg;

    // Stage two: five-term sum.
    logic                                  s2_valid_reg;
    logic                                  s2_last_reg;
    logic signed [jfps_pkg::SUM_BITS-1:0]  s2_sum_reg;
    logic signed [jfps_pkg::SUM_BITS-1:0]  sum_next;
    logic                                  s2_free;
    logic                                  scale_ready;
    jfps_pkg::stage_ctl_t                  scale_ctl;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Size registers are clamped on the way in and kept as the last padded index.
    always_comb
    begin
        cfg_w = cfg_data[CB-1:0];
        if (cfg_w == '0)
        begin
            cfg_w = CB'(1);
        end
        else if (cfg_w > CB'(jfps_pkg::WIDTH_MAX))
        begin
            cfg_w = CB'(jfps_pkg::WIDTH_MAX);
        end
        cfg_h = cfg_data[RB-1:0];
        if (cfg_h == '0)
        begin
            cfg_h = RB'(1);
        end
        else if (cfg_h > RB'(jfps_pkg::HEIGHT_MAX))
        begin
            cfg_h = RB'(jfps_pkg::HEIGHT_MAX);
        end
    end

    always_comb
    begin
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        unique case (cfg_index)
            jfps_pkg::REG_WIDTH:  last_col_next = cfg_w + CB'(1);
            jfps_pkg::REG_HEIGHT: last_row_next = cfg_h + RB'(1);
        endcase
    end

    assign in_emit = (row_reg >= RB'(2)) && (col_reg >= CB'(2));
    assign in_last = (row_reg == last_row_reg) && (col_reg == last_col_reg);

    always_comb
    begin
        if (col_reg >= last_col_reg)
        begin
            col_next = '0;
            row_next = (row_reg >= last_row_reg) ? '0 : row_reg + RB'(1);
        end
        else
        begin
            col_next = col_reg + CB'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= CB'(jfps_pkg::WIDTH_RESET + 1);
            last_row_reg <= RB'(jfps_pkg::HEIGHT_RESET + 1);
        end
        else if (cfg_we)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Read at accept, write back when the word leaves stage one. The next read of
    // the same column is a whole padded row later, so the two never meet.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem_rd_reg <= line_mem[col_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            line_mem[s1_col_reg] <= {near_val, s1_x_reg};
        end
    end

    assign near_val = mem_rd_reg[DB-1:0];
    assign far_val  = mem_rd_reg[2*DB-1:DB];

    assign s2_free       = !s2_valid_reg || scale_ready;
    assign s1_move       = s1_valid_reg && s2_free;
    assign s_axis_tready = !s1_valid_reg || s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            s1_valid_reg <= s_axis_tvalid;
            s1_emit_reg  <= in_emit;
            s1_last_reg  <= in_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg <= col_reg;
            s1_x_reg   <= s_axis_tdata;
        end
    end

    // Up, left, centre, right, down around the cell one column back.
    assign sum_next = jfps_pkg::SUM_BITS'(up_reg) + jfps_pkg::SUM_BITS'(left_reg)
                    + jfps_pkg::SUM_BITS'(mid_reg) + jfps_pkg::SUM_BITS'(near_val)
                    + jfps_pkg::SUM_BITS'(down_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= '0;
            mid_reg  <= '0;
            left_reg <= '0;
            down_reg <= '0;
        end
        else if (s1_move)
        begin
            up_reg   <= far_val;
            left_reg <= mid_reg;
            mid_reg  <= near_val;
            down_reg <= signed'(s1_x_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_free)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_emit_reg)
        begin
            s2_sum_reg  <= sum_next;
            s2_last_reg <= s1_last_reg;
        end
    end

    assign scale_ctl.valid = s2_valid_reg;
    assign scale_ctl.last  = s2_last_reg;

    jfps_scale u_scale (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (scale_ctl),
        .sum           (s2_sum_reg),
        .ready         (scale_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/jfps_checker.sv]
// Port-level checks of the stencil unit and their binding to the top level.
`default_nettype none

module jfps_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              s_axis_tvalid,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [jfps_pkg::DATA_BITS-1:0]    m_axis_tdata,
    input wire logic                              m_axis_tlast
);

    logic in_idle;

    assign in_idle = !(s_axis_tvalid && s_axis_tready) && m_axis_tready;

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // The input side only backs up when a result is waiting on a stalled output.
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without a stalled output");

    // With no new words and a ready sink the pipeline drains.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_idle ##1 in_idle ##1 in_idle |=> !m_axis_tvalid && s_axis_tready)
        else $error("pipeline did not drain");

endmodule

bind jacobi_five_point_stencil_unit jfps_checker u_jfps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[test/testbench.sv]
// Self-checking streaming testbench for the five-point Jacobi stencil unit.
`timescale 1ns / 1ps

module testbench;

    import jfps_pkg::*;

    typedef struct {
        logic [DATA_BITS-1:0] value;
        logic                 last;
    } stencil_update_t;

    typedef enum {
        FILL_MAX,
        FILL_MIN,
        FILL_TIE,
        FILL_RANDOM,
        FILL_EXTREME,
        FILL_SMALL
    } fill_t;

    typedef enum {
        TRAFFIC_FREE,
        TRAFFIC_SPARSE_SEND,
        TRAFFIC_SLOW_SINK,
        TRAFFIC_BOTH
    } traffic_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [DATA_BITS-1:0]      s_axis_tdata = '0;   // cell_value
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [DATA_BITS-1:0]      m_axis_tdata;        // new_value
    logic                      m_axis_tlast;        // last_of_sweep

    // Words waiting for the driver, and updates the predictor has worked out.
    logic [DATA_BITS-1:0] grid_words[$];
    stencil_update_t      awaited_updates[$];

    // Predictor state: the two previous padded rows, the window and the position.
    logic [DATA_BITS-1:0] row_above[LINE_LENGTH] = '{default: '0};
    logic [DATA_BITS-1:0] row_two_above[LINE_LENGTH] = '{default: '0};
    logic [DATA_BITS-1:0] up_prev = '0;
    logic [DATA_BITS-1:0] mid_prev = '0;
    logic [DATA_BITS-1:0] mid_prev2 = '0;
    logic [DATA_BITS-1:0] down_prev = '0;
    logic [COL_BITS-1:0]  grid_col = '0;
    logic [ROW_BITS-1:0]  grid_row = '0;
    logic [COL_BITS-1:0]  width_reg = COL_BITS'(WIDTH_RESET);
    logic [ROW_BITS-1:0]  height_reg = ROW_BITS'(HEIGHT_RESET);

    logic word_taken = 1'b0;
    int   send_idle_pct = 0;
    int   rx_stall_pct = 0;
    int   error_count = 0;
    int   words_queued = 0;
    int   words_accepted = 0;
    int   updates_checked = 0;
    int   sweeps_seen = 0;
    int   register_writes = 0;

    jacobi_five_point_stencil_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 clk = ~clk;

    function automatic int unsigned padded_span(input int unsigned reg_value,
                                                input int unsigned limit);
        if (reg_value == 0)
        begin
            return 3;
        end
        if (reg_value > limit)
        begin
            return limit + 2;
        end
        return reg_value + 2;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (error_count < 100)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // Takes one padded-grid word and, once the window covers an interior cell,
    // records the scaled five-point sum for it.
    task automatic advance_stencil(input logic [DATA_BITS-1:0] grid_word);
        int unsigned          pad_w;
        int unsigned          pad_h;
        logic [DATA_BITS-1:0] near_word;
        logic [DATA_BITS-1:0] far_word;
        longint               five_sum;
        longint               scaled;
        stencil_update_t      upd;
        pad_w = padded_span(width_reg, WIDTH_MAX);
        pad_h = padded_span(height_reg, HEIGHT_MAX);
        near_word = row_above[grid_col];
        far_word = row_two_above[grid_col];
        if (grid_row >= 2 && grid_col >= 2)
        begin
            five_sum = longint'($signed(up_prev)) + longint'($signed(mid_prev2))
                     + longint'($signed(mid_prev)) + longint'($signed(near_word))
                     + longint'($signed(down_prev));
            // Multiply by 13107/65536 and round to nearest, ties upwards.
            scaled = (five_sum * COEF_MUL + (longint'(1) << (COEF_SHIFT - 1))) >>> COEF_SHIFT;
            upd.value = scaled[DATA_BITS-1:0];
            upd.last = (grid_row == pad_h - 1) && (grid_col == pad_w - 1);
            awaited_updates.push_back(upd);
        end
        up_prev = far_word;
        mid_prev2 = mid_prev;
        mid_prev = near_word;
        down_prev = grid_word;
        row_two_above[grid_col] = near_word;
        row_above[grid_col] = grid_word;
        if (grid_col >= pad_w - 1)
        begin
            grid_col = '0;
            grid_row = (grid_row >= pad_h - 1) ? '0 : grid_row + 1'b1;
        end
        else
        begin
            grid_col = grid_col + 1'b1;
        end
    endtask

    // Driver: offers the next word once the current one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || word_taken))
        begin
            if (grid_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= grid_words.pop_front();
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= $urandom;
            end
        end
    end

    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Monitor: follows register writes and accepted words, and checks each result word.
    always @(posedge clk)
    begin : monitor
        stencil_update_t head;
        word_taken = 1'b0;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_WIDTH)
                begin
                    width_reg = cfg_data[COL_BITS-1:0];
                end
                else
                begin
                    height_reg = cfg_data[ROW_BITS-1:0];
                end
                grid_col = '0;
                grid_row = '0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                word_taken = 1'b1;
                words_accepted++;
                advance_stencil(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_updates.size() == 0)
                begin
                    flag_mismatch($sformatf("result %h arrived with none outstanding",
                                            m_axis_tdata));
                end
                else
                begin
                    head = awaited_updates.pop_front();
                    if (m_axis_tdata !== head.value)
                    begin
                        flag_mismatch($sformatf("new_value %h, predicted %h",
                                                m_axis_tdata, head.value));
                    end
                    if (m_axis_tlast !== head.last)
                    begin
                        flag_mismatch($sformatf("last_of_sweep %b, predicted %b",
                                                m_axis_tlast, head.last));
                    end
                    updates_checked++;
                    if (head.last)
                    begin
                        sweeps_seen++;
                    end
                end
            end
        end
    end

    function automatic logic [DATA_BITS-1:0] grid_value(input fill_t fill, input int idx);
        case (fill)
            FILL_MAX:     return {1'b0, {(DATA_BITS-1){1'b1}}};
            FILL_MIN:     return {1'b1, {(DATA_BITS-1){1'b0}}};
            FILL_TIE:     return (idx == 4) ? DATA_BITS'(32768) : '0;
            FILL_EXTREME:
            begin
                case ($urandom_range(0, 4))
                    0:       return {1'b0, {(DATA_BITS-1){1'b1}}};
                    1:       return {1'b1, {(DATA_BITS-1){1'b0}}};
                    2:       return '0;
                    3:       return '1;
                    default: return $urandom;
                endcase
            end
            FILL_SMALL:   return DATA_BITS'($urandom_range(0, 2047) - 1024);
            default:      return $urandom;
        endcase
    endfunction

    task automatic queue_words(input int count, input fill_t fill);
        @(posedge clk);
        for (int i = 0; i < count; i++)
        begin
            grid_words.push_back(grid_value(fill, i));
        end
        words_queued += count;
    endtask

    // Waits until every word is in and every update out, then lets the pipeline drain.
    task automatic settle_grid();
        do
        begin
            @(negedge clk);
        end
        while (words_accepted != words_queued || awaited_updates.size() != 0);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        register_writes++;
    endtask

    task automatic set_traffic(input traffic_t mode);
        case (mode)
            TRAFFIC_SPARSE_SEND:
            begin
                send_idle_pct = 62;
                rx_stall_pct = 0;
            end
            TRAFFIC_SLOW_SINK:
            begin
                send_idle_pct = 0;
                rx_stall_pct = 62;
            end
            TRAFFIC_BOTH:
            begin
                send_idle_pct = 29;
                rx_stall_pct = 29;
            end
            default:
            begin
                send_idle_pct = 0;
                rx_stall_pct = 0;
            end
        endcase
    endtask

    initial
    begin
        int          random_words;
        int          phase;
        int unsigned width_sel;
        int unsigned height_sel;
        int unsigned span;
        int          sweeps;
        fill_t       fill;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Smallest grid, full-scale sums of both signs, then a rounding tie.
        set_traffic(TRAFFIC_FREE);
        settle_grid();
        write_register(REG_WIDTH, CFG_DATA_BITS'(1));
        write_register(REG_HEIGHT, CFG_DATA_BITS'(1));
        queue_words(9, FILL_MAX);
        settle_grid();
        // Zero sizes are taken as one; the second sweep follows without any write.
        write_register(REG_WIDTH, '0);
        write_register(REG_HEIGHT, '0);
        queue_words(9, FILL_MIN);
        queue_words(9, FILL_TIE);

        // Width register above the limit, with junk in the unused upper bits. The
        // sweep is left part-way along the top row and the next write restarts it.
        settle_grid();
        set_traffic(TRAFFIC_BOTH);
        write_register(REG_WIDTH, {6'($urandom), 10'h3FF});
        write_register(REG_HEIGHT, CFG_DATA_BITS'(1));
        queue_words(40, FILL_RANDOM);

        // Tallest grid, abandoned after a dozen rows; the next write restarts it.
        settle_grid();
        set_traffic(TRAFFIC_SLOW_SINK);
        write_register(REG_WIDTH, CFG_DATA_BITS'(1));
        write_register(REG_HEIGHT, 16'hFFFF);
        queue_words(3 * 12 + 2, FILL_EXTREME);
        width_sel = 1;
        height_sel = 16'hFFFF;

        random_words = 0;
        phase = 0;
        while (random_words < 1300)
        begin
            settle_grid();
            set_traffic(traffic_t'(phase % 4));
            case ($urandom_range(0, 4))
                0:
                begin
                    width_sel = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                           : $urandom_range(9, 40);
                    write_register(REG_WIDTH, {6'($urandom), 10'(width_sel)});
                end
                1:
                begin
                    height_sel = $urandom_range(1, 6);
                    write_register(REG_HEIGHT, CFG_DATA_BITS'(height_sel));
                end
                default:
                begin
                    width_sel = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                           : $urandom_range(9, 40);
                    height_sel = $urandom_range(1, 6);
                    write_register(REG_HEIGHT, CFG_DATA_BITS'(height_sel));
                    write_register(REG_WIDTH, {6'($urandom), 10'(width_sel)});
                end
            endcase
            // The tall setting may still be in force; keep random sweeps short.
            if (height_sel > 6)
            begin
                height_sel = $urandom_range(1, 6);
                write_register(REG_HEIGHT, CFG_DATA_BITS'(height_sel));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: fill = FILL_RANDOM;
                6, 7:             fill = FILL_EXTREME;
                default:          fill = FILL_SMALL;
            endcase
            span = padded_span(width_sel, WIDTH_MAX) * padded_span(height_sel, HEIGHT_MAX);
            sweeps = $urandom_range(1, 3);
            for (int s = 0; s < sweeps; s++)
            begin
                queue_words(span, fill);
                random_words += span;
            end
            // Sometimes stop part-way through a sweep so that the next write restarts it.
            if ($urandom_range(0, 2) == 0)
            begin
                sweeps = $urandom_range(1, span - 1);
                queue_words(sweeps, fill);
                random_words += sweeps;
            end
            phase++;
        end

        settle_grid();
        $display("Streamed %0d grid words over %0d register writes and %0d phases.",
                 words_accepted, register_writes, phase);
        $display("Checked %0d updated cells, %0d of them closing a sweep.",
                 updates_checked, sweeps_seen);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Run timed out with %0d updates outstanding.", awaited_updates.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
